// File: src/crp_pkg.sv
package crp_pkg;

  localparam int CMD_W      = 2;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int RGB_W      = 24;
  localparam int IDX_W      = 11;
  localparam int HGT_W      = 19;
  localparam int TOP_W      = 11;
  localparam int WID_W      = 11;
  localparam int STEP_W     = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_STEP  = 2'd2;

  localparam logic [WID_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [WID_W-1:0] IMAGE_HEIGHT_RST = 11'd1024;

  localparam int DEF_MAX_WIDTH      = 1024;
  localparam int DEF_SAMPLE_COUNT   = 2048;
  localparam int DEF_STEP_FRAC_BITS = 16;

  typedef logic [TOP_W-1:0] top_t;

endpackage

// File: src/crp_colmem.sv
module crp_colmem #(
  parameter int DEPTH = crp_pkg::DEF_MAX_WIDTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  crp_pkg::top_t wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output crp_pkg::top_t rdata0,
  output crp_pkg::top_t rdata1
);

  crp_pkg::top_t mem [DEPTH];

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// File: src/column_top_profile_resampler_unit.sv
// Column top profile resampler. Keeps, per image column, the highest solid row
// plus one in a MAX_WIDTH-entry column memory and answers height queries by
// linear interpolation between two adjacent columns. Pixel items sustain one
// per cycle: the column entry is read in the accept cycle and written back the
// next, with a forward path for back-to-back pixels on the same column. A
// height query steps through position multiply, two-port memory read,
// interpolation multiply, and sum and saturate, and another item is not taken
// until it has moved into the output register. A clear item, and reset, start
// a sweep that zeroes the column memory one entry per cycle, with in_stall
// high throughout; configuration writes are taken during the sweep.
module column_top_profile_resampler_unit #(
  parameter int MAX_WIDTH      = crp_pkg::DEF_MAX_WIDTH,
  parameter int SAMPLE_COUNT   = crp_pkg::DEF_SAMPLE_COUNT,
  parameter int STEP_FRAC_BITS = crp_pkg::DEF_STEP_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [crp_pkg::CMD_W-1:0]           in_cmd,
  input  logic [crp_pkg::COL_W-1:0]           in_column,
  input  logic [crp_pkg::ROW_W-1:0]           in_row,
  input  logic [crp_pkg::RGB_W-1:0]           in_pixel_rgb,
  input  logic [crp_pkg::IDX_W-1:0]           in_sample_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [crp_pkg::IDX_W-1:0]           out_sample_number,
  output logic signed [crp_pkg::HGT_W-1:0]    out_height_value
);

  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WW    = ((AW > crp_pkg::WID_W) ? AW : crp_pkg::WID_W) + 1;
  localparam int POS_W = crp_pkg::IDX_W + crp_pkg::STEP_W;
  localparam int CI_W  = POS_W - STEP_FRAC_BITS;
  localparam int SH    = STEP_FRAC_BITS - 8;
  localparam int DIF_W = crp_pkg::TOP_W + 1;
  localparam int PRD_W = DIF_W + STEP_FRAC_BITS + 1;
  localparam int VW    = crp_pkg::TOP_W + 12;
  localparam int HW    = crp_pkg::HGT_W;
  localparam logic [63:0] STEP_RST =
    (64'(MAX_WIDTH) << STEP_FRAC_BITS) / SAMPLE_COUNT;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_WIDTH - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PWR, S_QADDR, S_QDATA, S_QSUM
  } state_t;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [crp_pkg::IDX_W-1:0] out_num_r, out_num_nxt;
  logic signed [HW-1:0] out_hgt_r, out_hgt_nxt;

  logic [crp_pkg::WID_W-1:0] width_r, height_r;
  logic [crp_pkg::STEP_W-1:0] step_r;

  logic [crp_pkg::COL_W-1:0] pcol_r;
  crp_pkg::top_t ptop_r, fwd_val_r, t0_r;
  logic pv_r, fwd_r, sat_r;
  logic [crp_pkg::IDX_W-1:0] idx_r;
  logic [POS_W-1:0] pos_r;
  logic [STEP_FRAC_BITS-1:0] frac_r;
  logic signed [PRD_W-1:0] prod_r;

  logic in_acc, load_out;
  logic mem_we;
  logic [AW-1:0] mem_waddr, rd_addr0, rd_addr1, in_addr, pcol_addr;
  crp_pkg::top_t mem_wdata, rd0, rd1, cur, new_top, in_top;
  logic in_pv;
  logic [WW-1:0] w_eff, last_w;
  logic [CI_W-1:0] ci;
  logic sat;
  logic signed [DIF_W-1:0] diff;
  logic signed [STEP_FRAC_BITS:0] frac_s;
  logic signed [PRD_W-1:0] prod_sh;
  logic signed [VW-1:0] val;
  logic in_range;

  assign in_stall  = !(state_r == S_IDLE || state_r == S_PWR);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_sample_number = out_num_r;
  assign out_height_value  = out_hgt_r;

  // pixel path
  assign in_addr   = AW'(WW'(in_column));
  assign pcol_addr = AW'(WW'(pcol_r));
  assign in_pv     = (in_pixel_rgb != '0) && (WW'(in_column) < WW'(MAX_WIDTH));
  assign in_top    = crp_pkg::TOP_W'(in_row) + crp_pkg::TOP_W'(1);
  assign cur       = fwd_r ? fwd_val_r : rd0;
  assign new_top   = (pv_r && ptop_r > cur) ? ptop_r : cur;

  // query addressing
  always_comb begin
    w_eff = WW'(width_r);
    if (w_eff == '0) begin
      w_eff = WW'(1);
    end else if (w_eff > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
  end
  assign last_w = w_eff - WW'(1);
  assign ci     = pos_r[POS_W-1:STEP_FRAC_BITS];
  assign sat    = ci >= CI_W'(last_w);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pcol_addr;
    mem_wdata = ptop_r;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (state_r == S_PWR) begin
      mem_we = pv_r && (ptop_r > cur);
    end
  end

  always_comb begin
    rd_addr0 = in_addr;
    rd_addr1 = in_addr;
    if (state_r == S_QADDR) begin
      rd_addr0 = sat ? last_w[AW-1:0] : ci[AW-1:0];
      rd_addr1 = ci[AW-1:0] + AW'(1);
    end
  end

  crp_colmem #(
    .DEPTH(MAX_WIDTH),
    .AW   (AW)
  ) u_colmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(rd0),
    .rdata1(rd1)
  );

  // interpolation and saturation
  assign diff    = $signed({1'b0, rd1}) - $signed({1'b0, rd0});
  assign frac_s  = $signed({1'b0, frac_r});
  assign prod_sh = prod_r >>> SH;
  assign val     = $signed(VW'({t0_r, 8'b0})) - $signed(VW'({height_r, 7'b0}))
                 + VW'(prod_sh);
  assign in_range = (val[VW-1:HW-1] == '0) || (val[VW-1:HW-1] == '1);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_num_nxt   = out_num_r;
    out_hgt_nxt   = out_hgt_r;
    load_out      = (state_r == S_QSUM) && (!out_valid_r || !out_stall);
    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE, S_PWR: begin
        state_nxt = S_IDLE;
        if (in_acc) begin
          case (in_cmd)
            crp_pkg::CMD_CLEAR: begin
              state_nxt   = S_CLEAR;
              clr_cnt_nxt = '0;
            end
            crp_pkg::CMD_PIXEL: state_nxt = S_PWR;
            crp_pkg::CMD_QUERY: state_nxt = S_QADDR;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_QADDR: state_nxt = S_QDATA;
      S_QDATA: state_nxt = S_QSUM;
      S_QSUM: begin
        if (load_out) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_num_nxt   = idx_r;
          if (in_range) begin
            out_hgt_nxt = val[HW-1:0];
          end else if (val[VW-1]) begin
            out_hgt_nxt = {1'b1, {(HW-1){1'b0}}};
          end else begin
            out_hgt_nxt = {1'b0, {(HW-1){1'b1}}};
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_num_r   <= out_num_nxt;
      out_hgt_r   <= out_hgt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= crp_pkg::IMAGE_WIDTH_RST;
      height_r <= crp_pkg::IMAGE_HEIGHT_RST;
      step_r   <= crp_pkg::STEP_W'(STEP_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        crp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[crp_pkg::WID_W-1:0];
        crp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_wdata[crp_pkg::WID_W-1:0];
        crp_pkg::REG_COLUMN_STEP:  step_r   <= cfg_wdata[crp_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pcol_r    <= in_column;
      ptop_r    <= in_top;
      pv_r      <= in_pv;
      fwd_r     <= (state_r == S_PWR) && (in_column == pcol_r);
      fwd_val_r <= new_top;
      idx_r     <= in_sample_index;
      pos_r     <= POS_W'(in_sample_index) * POS_W'(step_r);
    end
    if (state_r == S_QADDR) begin
      sat_r  <= sat;
      frac_r <= pos_r[STEP_FRAC_BITS-1:0];
    end
    if (state_r == S_QDATA) begin
      t0_r   <= rd0;
      prod_r <= sat_r ? '0 : PRD_W'(diff * frac_s);
    end
  end

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && clr_cnt_r == CLR_LAST) |=> state_r == S_IDLE)
    else $error("clear sweep did not end after the last entry");

  a_fwd_only_chained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PWR && fwd_r) |-> $past(state_r) == S_PWR)
    else $error("forward flag set without a preceding pixel write-back");

  a_adjacent_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QADDR && !sat) |-> rd_addr1 == rd_addr0 + AW'(1))
    else $error("interpolation reads are not adjacent columns");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QSUM && out_valid_r && out_stall)
      |=> (out_valid_r && state_r == S_QSUM && $stable(out_hgt_r)))
    else $error("pending result overwritten by a new query");

endmodule
